// ----- rtl/wildcard_byte_pattern_scanner_unit_macros.svh -----
// Assertion macros for the wildcard byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define WBPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbps assertion failed");
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps assertion failed");
`else
`define WBPS_ASSERT_SAME(lbl, ante, cons)
`define WBPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/wbps_pkg.sv -----
// Package with constants and types of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int WBPS_MAX_PATTERN = 32;
  localparam int WBPS_ADDR_BITS   = 64;
  localparam int WIN_DEPTH        = 32;
  localparam int LEN_W            = 6;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT0  = 3'd0,
    CFG_PAT1  = 3'd1,
    CFG_PAT2  = 3'd2,
    CFG_PAT3  = 3'd3,
    CFG_WILD  = 3'd4,
    CFG_LEN   = 3'd5,
    CFG_LIMIT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pat;
    logic       wild;
    logic       used;
  } cell_cfg_t;

  typedef struct packed {
    logic valid;
    logic start;
  } stage_ctl_t;

endpackage

// ----- rtl/wildcard_byte_pattern_scanner_unit.sv -----
// Top level of the wildcard byte pattern scanner: config registers, cell row, match stage.
// m_tvalid follows a match's last byte via the cell hit registers and output register.
// Throughput: one byte per cycle unless m_tready stalls the output; the cell row shifts
// and compares every transfer, and the match stage counts one item per cycle in order.
// Reset (rst, synchronous): clears config registers, window valid bits, match count
// and output valid; no clearing pass is needed.
module wildcard_byte_pattern_scanner_unit
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = WBPS_MAX_PATTERN,
  parameter int ADDR_BITS   = WBPS_ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // data_byte, byte_address, zero fill
  input  logic [((8+ADDR_BITS+7)/8)*8-1:0]   s_tdata,
  // region_first, scan_start
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // match_address, zero fill
  output logic [((ADDR_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [63:0]                        cfg_data
);

  localparam int NCELL    = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
  localparam int M_DATA_W = ((ADDR_BITS + 7) / 8) * 8;

  logic [63:0]          pat_word [4];
  logic [31:0]          wild_mask;
  logic [LEN_W-1:0]     pat_len;
  logic [31:0]          match_limit;
  logic [255:0]         pat_flat;

  logic                 accept;
  logic                 clear;
  logic                 out_free;
  stage_ctl_t           ctl;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] match_addr;

  logic [7:0]           win_byte  [NCELL];
  logic [NCELL-1:0]     win_valid;
  logic [NCELL-1:0]     cell_hit;

  assign cfg_ready = 1'b1;
  assign pat_flat  = {pat_word[3], pat_word[2], pat_word[1], pat_word[0]};
  assign accept    = s_tvalid && s_tready;
  assign clear     = s_tuser[0] || s_tuser[1];
  assign s_tready  = !ctl.valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_word[0] <= 64'd0;
      pat_word[1] <= 64'd0;
      pat_word[2] <= 64'd0;
      pat_word[3] <= 64'd0;
      wild_mask   <= 32'd0;
      pat_len     <= '0;
      match_limit <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAT0:  pat_word[0] <= cfg_data;
        CFG_PAT1:  pat_word[1] <= cfg_data;
        CFG_PAT2:  pat_word[2] <= cfg_data;
        CFG_PAT3:  pat_word[3] <= cfg_data;
        CFG_WILD:  wild_mask   <= cfg_data[31:0];
        CFG_LEN:   pat_len     <= cfg_data[LEN_W-1:0];
        CFG_LIMIT: match_limit <= cfg_data[31:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (accept) begin
      ctl.valid <= 1'b1;
    end else if (out_free) begin
      ctl.valid <= 1'b0;
    end
    if (accept) begin
      ctl.start <= s_tuser[1];
      addr      <= s_tdata[8 +: ADDR_BITS];
    end
  end

  for (genvar d = 0; d < NCELL; d++) begin : g_cell
    logic [LEN_W-1:0] diff;
    logic [4:0]       pos;
    cell_cfg_t        ccfg;
    logic [7:0]       byte_in;
    logic             valid_in;

    assign diff      = pat_len - LEN_W'(d + 1);
    assign pos       = diff[4:0];
    assign ccfg.used = LEN_W'(d) < pat_len;
    assign ccfg.wild = wild_mask[pos];
    assign ccfg.pat  = pat_flat[pos*8 +: 8];

    if (d == 0) begin : g_head
      assign byte_in  = s_tdata[7:0];
      assign valid_in = 1'b1;
    end else begin : g_body
      assign byte_in  = win_byte[d-1];
      assign valid_in = win_valid[d-1] && !clear;
    end

    wbps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .byte_in   (byte_in),
      .valid_in  (valid_in),
      .cfg       (ccfg),
      .win_byte  (win_byte[d]),
      .win_valid (win_valid[d]),
      .hit       (cell_hit[d])
    );
  end

  wbps_match #(
    .ADDR_BITS (ADDR_BITS),
    .NCELL     (NCELL)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .addr     (addr),
    .cell_hit (cell_hit),
    .len      (pat_len),
    .limit    (match_limit),
    .out_free (out_free),
    .m_valid  (m_tvalid),
    .m_addr   (match_addr),
    .m_last   (m_tlast),
    .m_ready  (m_tready)
  );

  assign m_tdata = M_DATA_W'(match_addr);

endmodule

// ----- rtl/wbps_cell.sv -----
// One window cell: holds a byte and its valid bit, compares against its pattern byte.
module wbps_cell
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic       valid_in,
  input  cell_cfg_t  cfg,
  output logic [7:0] win_byte,
  output logic       win_valid,
  output logic       hit
);

  logic hit_next;

  assign hit_next = !cfg.used || (valid_in && (cfg.wild || (byte_in == cfg.pat)));

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (shift) begin
      win_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      win_byte <= byte_in;
      hit      <= hit_next;
    end
  end

endmodule

// ----- rtl/wbps_match.sv -----
// Match stage: combines cell hits, counts matches per scan, holds the output register.
`include "wildcard_byte_pattern_scanner_unit_macros.svh"
module wbps_match
  import wbps_pkg::*;
#(
  parameter int ADDR_BITS = WBPS_ADDR_BITS,
  parameter int NCELL     = WIN_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stage_ctl_t           ctl,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [NCELL-1:0]     cell_hit,
  input  logic [LEN_W-1:0]     len,
  input  logic [31:0]          limit,
  output logic                 out_free,
  output logic                 m_valid,
  output logic [ADDR_BITS-1:0] m_addr,
  output logic                 m_last,
  input  logic                 m_ready
);

  logic        len_ok;
  logic        hit;
  logic        emit;
  logic [31:0] cnt;
  logic [31:0] cnt_base;
  logic [31:0] cnt_inc;

  assign len_ok   = (len != '0) && (len <= LEN_W'(NCELL));
  assign hit      = ctl.valid && len_ok && (&cell_hit);
  assign cnt_base = ctl.start ? 32'd0 : cnt;
  assign cnt_inc  = cnt_base + 32'd1;
  assign emit     = hit && (cnt_base < limit);
  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= 32'd0;
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= emit;
      if (ctl.valid) begin
        cnt <= emit ? cnt_inc : cnt_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      m_addr <= addr - ADDR_BITS'(len) + ADDR_BITS'(1);
      m_last <= cnt_inc >= limit;
    end
  end

  `WBPS_ASSERT_SAME(a_count_nonzero, m_valid, cnt != 32'd0)
  `WBPS_ASSERT_SAME(a_last_at_limit, m_valid && m_last, cnt == limit)
  `WBPS_ASSERT_NEXT(a_stall_holds_count, m_valid && !m_ready, $stable(cnt))

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the wildcard byte pattern scanner with random regions and stalls.
`timescale 1ns / 1ps

module testbench;
  import wbps_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 750;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]  data;
    logic [63:0] addr;
    logic        first;
    logic        start;
  } scan_byte_t;

  typedef struct packed {
    logic [63:0] addr;
    logic        last;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((8+WBPS_ADDR_BITS+7)/8)*8-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((WBPS_ADDR_BITS+7)/8)*8-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  wildcard_byte_pattern_scanner_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner state as predicted
  logic [63:0] sig_words [4] = '{default: '0};
  logic [31:0] wild_mask = '0;
  logic [LEN_W-1:0] sig_len = '0;
  logic [31:0] hit_limit = '0;
  logic [7:0] window_bytes [WIN_DEPTH] = '{default: '0};
  int window_fill = 0;
  logic [31:0] hits_in_scan = '0;

  scan_byte_t pending_bytes [$];
  match_t expected_matches [$];
  scan_byte_t drive_byte;
  bit took = 0;
  int tx_hold = 0;
  int rx_hold = 0;
  int tx_mode = 0;
  int rx_mode = 0;
  int cycles = 0;
  int failures = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int matches_checked = 0;
  int limit_flags = 0;
  int setups = 0;
  logic [63:0] next_addr;

  function automatic logic [7:0] pattern_byte(int pos);
    return sig_words[pos / 8][(pos % 8) * 8 +: 8];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: sig_words[idx[1:0]] = val;
      CFG_WILD: wild_mask = val[31:0];
      CFG_LEN: sig_len = val[LEN_W-1:0];
      CFG_LIMIT: hit_limit = val[31:0];
      default: begin
      end
    endcase
  endfunction

  function automatic void advance_window(scan_byte_t b);
    match_t m;
    int len;
    if (b.start) hits_in_scan = '0;
    if (b.start || b.first) begin
      foreach (window_bytes[i]) window_bytes[i] = '0;
      window_fill = 0;
    end
    for (int i = 0; i < WIN_DEPTH - 1; i++) window_bytes[i] = window_bytes[i+1];
    window_bytes[WIN_DEPTH-1] = b.data;
    if (window_fill < WIN_DEPTH) window_fill++;
    len = sig_len;
    if (len == 0 || len > WIN_DEPTH) return;
    if (hits_in_scan >= hit_limit) return;
    if (window_fill < len) return;
    for (int i = 0; i < len; i++) begin
      if (!wild_mask[i] && window_bytes[WIN_DEPTH-len+i] != pattern_byte(i)) return;
    end
    hits_in_scan++;
    m.addr = b.addr - 64'(len - 1);
    m.last = (hits_in_scan >= hit_limit);
    expected_matches = {expected_matches, m};
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95 || mode == 1) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        advance_window(drive_byte);
        bytes_sent++;
        took = 1;
      end
      if (m_tvalid && m_tready) begin
        matches_checked++;
        if (m_tlast) limit_flags++;
        if (expected_matches.size() == 0) begin
          $error("unexpected match: match_address %h limit_reached %b", m_tdata, m_tlast);
          failures++;
        end else begin
          match_t m;
          m = expected_matches.pop_front();
          if (m_tdata[63:0] !== m.addr) begin
            $error("match_address: expected %h, actual %h", m.addr, m_tdata[63:0]);
            failures++;
          end
          if (m_tlast !== m.last) begin
            $error("limit_reached: expected %b, actual %b", m.last, m_tlast);
            failures++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !took) begin
    end else if (tx_hold > 0) begin
      s_tvalid <= 1'b0;
      tx_hold--;
    end else if (pending_bytes.size() > 0) begin
      drive_byte = pending_bytes.pop_front();
      s_tdata <= {drive_byte.addr, drive_byte.data};
      s_tuser <= {drive_byte.start, drive_byte.first};
      s_tvalid <= 1'b1;
      tx_hold = pick_gap(tx_mode);
    end else begin
      s_tvalid <= 1'b0;
    end
    took = 0;
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
      rx_hold = pick_gap(rx_mode);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] data, logic [63:0] addr, bit first, bit start);
    scan_byte_t b;
    b.data = data;
    b.addr = addr;
    b.first = first;
    b.start = start;
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  // hold until the block has drained, then let its pipeline settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_matches.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_setup();
    int r;
    setups++;
    for (int w = 0; w < 4; w++) begin
      if ($urandom_range(0, 99) < 50) begin
        r = $urandom_range(0, 99);
        write_reg(CFG_IDX_W'(CFG_PAT0 + w),
                  r < 10 ? 64'h0 : r < 20 ? ALL_ONES : {$urandom, $urandom});
      end
    end
    if ($urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 99);
      write_reg(CFG_WILD, r < 35 ? 64'h0 : r < 45 ? 64'hFFFF_FFFF :
                r < 75 ? 64'($urandom & $urandom) : 64'($urandom));
    end
    if ($urandom_range(0, 99) < 70) begin
      r = $urandom_range(0, 99);
      write_reg(CFG_LEN, r < 70 ? 64'($urandom_range(1, 6)) :
                r < 80 ? 64'($urandom_range(7, 32)) :
                r < 85 ? 64'd32 : r < 90 ? 64'd0 : 64'($urandom_range(33, 63)));
    end
    if ($urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 99);
      write_reg(CFG_LIMIT, r < 50 ? 64'($urandom_range(1, 4)) : r < 65 ? 64'hFFFF_FFFF :
                r < 72 ? 64'd0 : 64'($urandom_range(5, 20)));
    end
    if ($urandom_range(0, 99) < 5) write_reg(CFG_SPARE, {$urandom, $urandom});
  endtask

  task automatic random_bytes();
    int budget;
    int region_len;
    int pos;
    int eff_len;
    int r;
    bit new_scan;
    logic [7:0] b;
    budget = $urandom_range(25, 45);
    new_scan = ($urandom_range(0, 99) < 80);
    eff_len = (sig_len == 0 || sig_len > WIN_DEPTH) ? $urandom_range(1, 8) : sig_len;
    while (budget > 0) begin
      region_len = $urandom_range(1, eff_len + 24);
      r = $urandom_range(0, 99);
      next_addr = r < 20 ? ALL_ONES - $urandom_range(0, 40) :
                  r < 30 ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
      pos = 0;
      while (pos < region_len) begin
        if (pos + eff_len <= region_len && $urandom_range(0, 99) < 30) begin
          for (int k = 0; k < eff_len; k++) begin
            b = (wild_mask[k] || $urandom_range(0, 19) == 0) ? 8'($urandom) : pattern_byte(k);
            push_byte(b, next_addr, pos == 0 || $urandom_range(0, 99) < 2,
                      (pos == 0 && new_scan) || $urandom_range(0, 99) < 2);
            next_addr++;
            pos++;
            new_scan = 0;
            budget--;
          end
        end else begin
          b = $urandom_range(0, 1) ? pattern_byte($urandom_range(0, eff_len - 1)) :
                                     8'($urandom);
          push_byte(b, next_addr, pos == 0 || $urandom_range(0, 99) < 2,
                    (pos == 0 && new_scan) || $urandom_range(0, 99) < 2);
          next_addr++;
          pos++;
          new_scan = 0;
          budget--;
        end
      end
    end
  endtask

  initial begin
    int directed;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset values: zero length, nothing reported
    setups++;
    push_byte(8'h00, 64'h0, 1, 1);
    push_byte(8'hFF, 64'h1, 0, 0);
    push_byte(8'h00, 64'h2, 0, 0);
    wait_drained();

    // DE ?? BE EF, limit two, window across address wrap and a region boundary
    setups++;
    tx_mode = 1;
    rx_mode = 1;
    write_reg(CFG_PAT0, 64'h0000_0000_EFBE_00DE);
    write_reg(CFG_WILD, 64'h2);
    write_reg(CFG_LEN, 64'd4);
    write_reg(CFG_LIMIT, 64'd2);
    write_reg(CFG_SPARE, ALL_ONES);
    push_byte(8'hDE, ALL_ONES - 1, 1, 1);
    push_byte(8'h55, ALL_ONES, 0, 0);
    push_byte(8'hBE, 64'h0, 0, 0);
    push_byte(8'hEF, 64'h1, 0, 0);
    push_byte(8'hDE, 64'h100, 1, 0);
    push_byte(8'h11, 64'h101, 0, 0);
    push_byte(8'hBE, 64'h102, 0, 0);
    push_byte(8'hEF, 64'h103, 1, 0);
    push_byte(8'hDE, 64'h104, 0, 0);
    push_byte(8'h22, 64'h105, 0, 0);
    push_byte(8'hBE, 64'h106, 0, 0);
    push_byte(8'hEF, 64'h107, 0, 0);
    push_byte(8'hDE, 64'h108, 0, 0);
    push_byte(8'hA0, 64'h109, 0, 0);
    push_byte(8'hBE, 64'h10A, 0, 0);
    push_byte(8'hEF, 64'h10B, 0, 0);
    wait_drained();

    // single byte pattern, widest limit, then lengths beyond capacity and a zero limit
    setups++;
    for (int w = 0; w < 4; w++) write_reg(CFG_IDX_W'(CFG_PAT0 + w), ALL_ONES);
    write_reg(CFG_WILD, 64'h0);
    write_reg(CFG_LEN, 64'd1);
    write_reg(CFG_LIMIT, 64'hFFFF_FFFF);
    push_byte(8'hFF, 64'h0, 0, 1);
    push_byte(8'h00, ALL_ONES, 0, 0);
    push_byte(8'hFF, 64'h7, 0, 0);
    wait_drained();
    write_reg(CFG_LEN, 64'd33);
    push_byte(8'hFF, 64'h8, 0, 0);
    wait_drained();
    write_reg(CFG_LEN, 64'd63);
    push_byte(8'hFF, 64'h9, 0, 0);
    wait_drained();
    write_reg(CFG_LEN, 64'd1);
    write_reg(CFG_LIMIT, 64'h0);
    push_byte(8'hFF, 64'hA, 0, 1);
    wait_drained();
    directed = bytes_queued;

    while (bytes_queued - directed < RANDOM_BYTES && setups < 150) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      random_setup();
      random_bytes();
      wait_drained();
    end

    $display("Scanned %0d bytes under %0d register setups, %0d directed.",
             bytes_sent, setups, directed);
    $display("Checked %0d matches, %0d of them flagged at the match limit.",
             matches_checked, limit_flags);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- wildcard_byte_pattern_scanner_unit.f -----
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scanner_unit.sv
test/testbench.sv
